>>> sv/mcq_pkg.sv
// shared types, codes and field layout of the multicast consumer queue
package mcq_pkg;

   // defaults for the top-level parameters
   localparam int DEPTH_DEFAULT      = 16;
   localparam int CONSUMERS_DEFAULT  = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // fixed field widths
   localparam int CMD_W        = 2;
   localparam int DATA_IN_W    = 32;
   localparam int ID_W         = 3;
   localparam int MASK_W       = 8;
   localparam int CAP_W        = 5;
   localparam int ITEM_COUNT_W = 5;
   localparam int POP_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 8;

   // request tdata layout
   localparam int REQ_TDATA_W  = 40;
   localparam int REQ_ID_LSB   = 32;
   localparam int REQ_IDLE_BIT = 35;

   // response tdata layout
   localparam int RSP_TDATA_W    = 48;
   localparam int RSP_FOUND_BIT  = 32;
   localparam int RSP_OVF_BIT    = 33;
   localparam int RSP_COUNT_LSB  = 34;
   localparam int RSP_FULL_BIT   = 39;
   localparam int RSP_HAS_BIT    = 40;
   localparam int RSP_ACTIVE_BIT = 41;

   // register reset values
   localparam logic [MASK_W-1:0] MASK_RESET     = 8'd1;
   localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 2'd0,
      CMD_POP  = 2'd1,
      CMD_END  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MASK     = 1'b0,
      CSR_CAPACITY = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // status of one entry against the selected consumer bit
   typedef struct packed {
      logic any_hit;
      logic now_empty;
   } match_flags_type;

endpackage

>>> sv/multicast_consumer_queue_core.sv
// multicast consumer queue: sequencer, status registers and stream handshake
// a request is taken only while idle; the scan then reads one entry per cycle over the entries
//   held at the transfer, and the finish state loads the output register once it is free
// one request at a time; a finished response waits in the output register while the next
//   request is scanned
// reset is synchronous and active high; the queue comes up empty, active, mask 1, capacity 16
module multicast_consumer_queue_core import mcq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int CONSUMERS  = CONSUMERS_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // data_in, consumer_id, providers_idle, zero pad
   input  logic [CMD_W-1:0]       req_tuser,  // cmd
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // pop_data, pop_found, overflow, item_count,
                                              // full_res, has_items_for_id, queue_active, pad
   // register write port
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENTRY_W = CONSUMERS + DATA_WIDTH;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // ---------------------------------------------------------------- registers
   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [CONSUMERS-1:0]   bit_ff, bit_in;          // one-hot consumer select, zero if out of range
   logic                   idle_ff, idle_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       scan_len_ff, scan_len_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]       proc_idx_ff, proc_idx_in;
   logic                   found_ff, found_in;
   logic                   removing_ff, removing_in;
   logic                   has_ff, has_in;
   logic                   overflow_ff, overflow_in;
   logic [DATA_WIDTH-1:0]  pop_data_ff, pop_data_in;
   logic                   term_ff, term_in;
   logic                   active_ff, active_in;
   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ---------------------------------------------------------------- request decode
   cmd_type              in_cmd;
   logic [DATA_IN_W-1:0] in_data;
   logic [ID_W-1:0]      in_id;
   logic                 in_idle;
   logic [CONSUMERS-1:0] in_bit;
   logic [63:0]          mask_wide;
   logic [63:0]          data_wide;
   logic [CONSUMERS-1:0] push_readers;
   logic [DATA_WIDTH-1:0] push_data;
   logic                 push_full;
   logic                 push_store;
   logic                 req_accept;

   assign in_cmd  = cmd_type'(req_tuser);
   assign in_data = req_tdata[DATA_IN_W-1:0];
   assign in_id   = req_tdata[REQ_ID_LSB +: ID_W];
   assign in_idle = req_tdata[REQ_IDLE_BIT];

   // ids at or above CONSUMERS select nothing
   assign in_bit = (32'(in_id) < CONSUMERS) ? (CONSUMERS'(1) << in_id) : '0;

   // only the low CONSUMERS mask bits take part, data kept at DATA_WIDTH
   assign mask_wide    = 64'(mask_ff);
   assign push_readers = mask_wide[CONSUMERS-1:0];
   assign data_wide    = 64'(in_data);
   assign push_data    = data_wide[DATA_WIDTH-1:0];

   assign req_accept = req_tvalid & req_tready;
   assign push_full  = (count_ff == DEPTH_CNT);
   // an empty mask stores nothing, a full store drops the push
   assign push_store = req_accept && (in_cmd == CMD_PUSH) && !push_full && (|push_readers);

   // ---------------------------------------------------------------- scan datapath
   logic                  rd_issue;
   logic                  scan_done;
   logic                  slot_free;
   logic                  finish_fire;
   logic [IDX_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]    rd_entry;
   logic [CONSUMERS-1:0]  ent_readers;
   logic [DATA_WIDTH-1:0] ent_data;
   logic [CONSUMERS-1:0]  ent_cleared;
   match_flags_type       ent_flags;
   logic                  hit;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]    wr_data;

   assign rd_addr     = rd_idx_ff[IDX_W-1:0];
   assign ent_readers = rd_entry[DATA_WIDTH +: CONSUMERS];
   assign ent_data    = rd_entry[DATA_WIDTH-1:0];

   mcq_store #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   mcq_match #(
      .READ_W (CONSUMERS)
   ) u_match (
      .readers (ent_readers),
      .sel_bit (bit_ff),
      .cleared (ent_cleared),
      .flags   (ent_flags)
   );

   // first entry of a pop that still owes the consumer a read
   assign hit = rd_valid_ff && (cmd_ff == CMD_POP) && !found_ff && ent_flags.any_hit;

   // memory write port: push append, mask update on a hit, or compaction shift
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = proc_idx_ff;
      wr_data = {ent_readers, ent_data};
      if (push_store) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = {push_readers, push_data};
      end else if (hit && !ent_flags.now_empty) begin
         // entry stays, one reader fewer
         wr_en   = 1'b1;
         wr_addr = proc_idx_ff;
         wr_data = {ent_cleared, ent_data};
      end else if (rd_valid_ff && !hit && found_ff && removing_ff) begin
         // close the gap left by the drained entry, order kept
         wr_en   = 1'b1;
         wr_addr = proc_idx_ff - 1'b1;
         wr_data = {ent_readers, ent_data};
      end
   end

   // ---------------------------------------------------------------- finish values
   logic [CNT_W-1:0] count_fin;
   logic             term_fin;
   logic             active_fin;
   logic             full_fin;
   logic [63:0]      pop_data_wide;

   always_comb begin
      count_fin  = count_ff - CNT_W'(removing_ff);
      term_fin   = term_ff;
      active_fin = active_ff;
      case (cmd_ff)
         CMD_POP: begin
            // drained while terminating, found or not
            if ((count_fin == '0) && term_ff) begin
               active_fin = 1'b0;
            end
         end
         CMD_END: begin
            if (idle_ff) begin
               term_fin = 1'b1;
               if (count_ff == '0) begin
                  active_fin = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      full_fin      = (32'(count_fin) >= 32'(cap_ff));
      pop_data_wide = 64'(pop_data_ff);
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[POP_DATA_W-1:0]                 = pop_data_wide[POP_DATA_W-1:0];
      rsp_data_in[RSP_FOUND_BIT]                  = found_ff;
      rsp_data_in[RSP_OVF_BIT]                    = overflow_ff;
      rsp_data_in[RSP_COUNT_LSB +: ITEM_COUNT_W]  = ITEM_COUNT_W'(count_fin);
      rsp_data_in[RSP_FULL_BIT]                   = full_fin;
      rsp_data_in[RSP_HAS_BIT]                    = has_ff;
      rsp_data_in[RSP_ACTIVE_BIT]                 = active_fin;
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      rd_issue    = (state_ff == ST_SCAN) && (rd_idx_ff < scan_len_ff);
      scan_done   = (state_ff == ST_SCAN) && !rd_issue && !rd_valid_ff;
      slot_free   = !rsp_valid_ff || rsp_tready;
      finish_fire = (state_ff == ST_FINISH) && slot_free;
   end

   // ---------------------------------------------------------------- next values
   always_comb begin
      cmd_in      = cmd_ff;
      bit_in      = bit_ff;
      idle_in     = idle_ff;
      count_in    = count_ff;
      scan_len_in = scan_len_ff;
      rd_idx_in   = rd_idx_ff;
      found_in    = found_ff;
      removing_in = removing_ff;
      has_in      = has_ff;
      overflow_in = overflow_ff;
      pop_data_in = pop_data_ff;
      term_in     = term_ff;
      active_in   = active_ff;
      mask_in     = mask_ff;
      cap_in      = cap_ff;
      rd_valid_in = rd_issue;
      proc_idx_in = rd_addr;

      if (req_accept) begin
         cmd_in      = in_cmd;
         bit_in      = in_bit;
         idle_in     = in_idle;
         scan_len_in = count_ff;   // the pushed entry is counted in has_in directly
         rd_idx_in   = '0;
         found_in    = 1'b0;
         removing_in = 1'b0;
         pop_data_in = '0;
         overflow_in = (in_cmd == CMD_PUSH) && push_full;
         has_in      = push_store && (|(push_readers & in_bit));
         if (push_store) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (rd_issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      if (rd_valid_ff) begin
         if (hit) begin
            found_in    = 1'b1;
            pop_data_in = ent_data;
            removing_in = ent_flags.now_empty;
         end else begin
            has_in = has_ff | ent_flags.any_hit;
         end
      end

      if (finish_fire) begin
         count_in  = count_fin;
         term_in   = term_fin;
         active_in = active_fin;
      end

      if (finish_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_MASK:     mask_in = csr_wdata;
            CSR_CAPACITY: cap_in  = csr_wdata[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         term_ff      <= 1'b0;
         active_ff    <= 1'b1;
         mask_ff      <= MASK_RESET;
         cap_ff       <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_valid_ff  <= rd_valid_in;
         term_ff      <= term_in;
         active_ff    <= active_in;
         mask_ff      <= mask_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      bit_ff      <= bit_in;
      idle_ff     <= idle_in;
      scan_len_ff <= scan_len_in;
      proc_idx_ff <= proc_idx_in;
      found_ff    <= found_in;
      removing_ff <= removing_in;
      has_ff      <= has_in;
      overflow_ff <= overflow_in;
      pop_data_ff <= pop_data_in;
      if (finish_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/mcq_store.sv
// entry memory: one write port, one registered read port
module mcq_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 40,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> sv/mcq_match.sv
// shared reader-mask compare unit used once per scanned entry
module mcq_match import mcq_pkg::*; #(
   parameter int READ_W = 8
) (
   input  logic [READ_W-1:0] readers,
   input  logic [READ_W-1:0] sel_bit,
   output logic [READ_W-1:0] cleared,
   output match_flags_type   flags
);

   always_comb begin
      cleared         = readers & ~sel_bit;
      flags.any_hit   = |(readers & sel_bit);
      flags.now_empty = (cleared == '0);
   end

endmodule

>>> sv/mcq_checker.sv
// port-level checks of the multicast queue core and their bind
module mcq_checker import mcq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic saw_inactive_ff, saw_inactive_in;

   always_comb begin
      saw_inactive_in = saw_inactive_ff;
      if (rsp_tvalid && rsp_tready && !rsp_tdata[RSP_ACTIVE_BIT]) begin
         saw_inactive_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saw_inactive_ff <= 1'b0;
      end else begin
         saw_inactive_ff <= saw_inactive_in;
      end
   end

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one request at a time: busy right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // no pop result with overflow, and no data without a find
   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_FOUND_BIT] && rsp_tdata[RSP_OVF_BIT])
                     && (rsp_tdata[RSP_FOUND_BIT] || (rsp_tdata[POP_DATA_W-1:0] == '0)))
      else $error("inconsistent result flags");

   // once drained after termination the queue never becomes active again
   a_inactive_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && saw_inactive_ff |-> !rsp_tdata[RSP_ACTIVE_BIT])
      else $error("queue became active again");

   // reset leaves no response pending and the request side open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind multicast_consumer_queue_core mcq_checker u_mcq_checker (.*);

>>> bench/mcq_stream_checker.sv
// response predictor and checker for the multicast consumer queue stream ports
module mcq_stream_checker import mcq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]       req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending_count
);

   localparam int SLOTS   = DEPTH_DEFAULT;
   localparam int READERS = CONSUMERS_DEFAULT;

   typedef struct packed {
      logic [POP_DATA_W-1:0]   pop_data;
      logic                    pop_found;
      logic                    overflow;
      logic [ITEM_COUNT_W-1:0] item_count;
      logic                    full_res;
      logic                    waiting;
      logic                    active;
   } reply_type;

   // shadow copy of the queue contents and status
   logic [POP_DATA_W-1:0] slot_data    [SLOTS];
   logic [MASK_W-1:0]     slot_readers [SLOTS];
   int                    held;
   bit                    terminating;
   bit                    active;
   logic [MASK_W-1:0]     reader_mask;
   logic [CAP_W-1:0]      full_level;

   reply_type replies_due [$];
   int        errors = 0;

   assign error_count = errors;

   function automatic reply_type queue_step(cmd_type cmd, logic [DATA_IN_W-1:0] word,
                                            logic [ID_W-1:0] id, logic idle);
      reply_type         r;
      logic [MASK_W-1:0] sel;
      bit                hit;
      int                i;
      int                j;
      r   = '0;
      sel = (int'(id) < READERS) ? (MASK_W'(1) << id) : '0;
      hit = 0;
      case (cmd)
         CMD_PUSH: begin
            if (held >= SLOTS) begin
               r.overflow = 1'b1;
            end else if (reader_mask != '0) begin
               slot_data[held]    = word;
               slot_readers[held] = reader_mask;
               held++;
            end
         end
         CMD_POP: begin
            for (i = 0; i < held && !hit; i++) begin
               if ((slot_readers[i] & sel) != '0) begin
                  hit = 1;
                  r.pop_found = 1'b1;
                  r.pop_data  = slot_data[i];
                  slot_readers[i] &= ~sel;
                  if (slot_readers[i] == '0) begin
                     for (j = i; j + 1 < held; j++) begin
                        slot_data[j]    = slot_data[j + 1];
                        slot_readers[j] = slot_readers[j + 1];
                     end
                     held--;
                     slot_data[held]    = '0;
                     slot_readers[held] = '0;
                  end
               end
            end
            if (held == 0 && terminating) active = 0;
         end
         CMD_END: begin
            if (idle) begin
               terminating = 1;
               if (held == 0) active = 0;
            end
         end
         default: ;
      endcase
      r.item_count = ITEM_COUNT_W'(held);
      r.full_res   = (held >= int'(full_level));
      for (i = 0; i < held; i++)
         if ((slot_readers[i] & sel) != '0) r.waiting = 1'b1;
      r.active = active;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : monitor
      reply_type want;
      reply_type got;
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) begin
            slot_data[k]    = '0;
            slot_readers[k] = '0;
         end
         held        = 0;
         terminating = 0;
         active      = 1;
         reader_mask = MASK_RESET;
         full_level  = CAPACITY_RESET;
         replies_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.pop_data   = rsp_tdata[POP_DATA_W-1:0];
            got.pop_found  = rsp_tdata[RSP_FOUND_BIT];
            got.overflow   = rsp_tdata[RSP_OVF_BIT];
            got.item_count = rsp_tdata[RSP_COUNT_LSB +: ITEM_COUNT_W];
            got.full_res   = rsp_tdata[RSP_FULL_BIT];
            got.waiting    = rsp_tdata[RSP_HAS_BIT];
            got.active     = rsp_tdata[RSP_ACTIVE_BIT];
            if (replies_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = replies_due.pop_front();
               check_field("pop_data", want.pop_data, got.pop_data);
               check_field("pop_found", want.pop_found, got.pop_found);
               check_field("overflow", want.overflow, got.overflow);
               check_field("item_count", want.item_count, got.item_count);
               check_field("full_res", want.full_res, got.full_res);
               check_field("has_items_for_id", want.waiting, got.waiting);
               check_field("queue_active", want.active, got.active);
            end
         end
         if (req_tvalid && req_tready)
            replies_due.insert(replies_due.size(),
                               queue_step(cmd_type'(req_tuser), req_tdata[DATA_IN_W-1:0],
                                          req_tdata[REQ_ID_LSB +: ID_W],
                                          req_tdata[REQ_IDLE_BIT]));
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_MASK:     reader_mask = csr_wdata[MASK_W-1:0];
               CSR_CAPACITY: full_level  = csr_wdata[CAP_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= replies_due.size();
   end

endmodule

>>> bench/tb_top.sv
// stimulus and verdict for the multicast consumer queue core
module tb_top import mcq_pkg::*; ();

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // data_in, consumer_id, providers_idle, zero pad
   logic [CMD_W-1:0]       req_tuser  = CMD_NONE;  // cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // pop_data, pop_found, overflow, item_count,
                                       // full_res, has_items_for_id, queue_active, pad
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int                fail_count;
   int                outstanding;
   bit                steady   = 0;            // when set neither side inserts idle cycles
   logic [MASK_W-1:0] cur_mask = MASK_RESET;   // mask last written, steers pop ids

   multicast_consumer_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   mcq_stream_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .error_count   (fail_count),
      .pending_count (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // one request transfer: random gap, then hold valid until the block takes it
   // valid stays high into the next call when that one draws no gap
   task automatic send(cmd_type c, logic [DATA_IN_W-1:0] w, logic [ID_W-1:0] id, logic idle);
      int                     gap;
      logic [REQ_TDATA_W-1:0] t;
      gap = steady ? 0 : $urandom_range(0, 3);
      t = '0;
      t[DATA_IN_W-1:0]       = w;
      t[REQ_ID_LSB +: ID_W]  = id;
      t[REQ_IDLE_BIT]        = idle;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      req_tuser  <= c;
      do @(posedge clock); while (!req_tready);
   endtask

   // register write, only issued while nothing is in flight
   task automatic csr_write(csr_index_type a, logic [CSR_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (a == CSR_MASK) cur_mask = v[MASK_W-1:0];
   endtask

   // hold off new requests until every response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // mostly consumers that the current mask names, sometimes any id
   function automatic logic [ID_W-1:0] pick_reader();
      logic [ID_W-1:0] id;
      id = ID_W'($urandom_range(0, 7));
      if (cur_mask != '0 && $urandom_range(0, 4) != 0)
         while (!cur_mask[id]) id = ID_W'($urandom_range(0, 7));
      return id;
   endfunction

   // random command mix; end checks only terminate when allow_end is set
   task automatic run_random(int n, int push_pct, bit allow_end, int pause_at);
      int r;
      for (int k = 0; k < n; k++) begin
         if (k == pause_at) drain();
         r = $urandom_range(0, 99);
         if (r < push_pct)
            send(CMD_PUSH, $urandom(), pick_reader(), 1'($urandom_range(0, 1)));
         else if (r < 92)
            send(CMD_POP, $urandom(), pick_reader(), 1'($urandom_range(0, 1)));
         else if (r < 96)
            send(CMD_END, $urandom(), pick_reader(), allow_end & 1'($urandom_range(0, 1)));
         else
            send(CMD_NONE, $urandom(), pick_reader(), 1'($urandom_range(0, 1)));
      end
   endtask

   // response side: random back-pressure per transfer
   initial begin : sink
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      logic [MASK_W-1:0] m;
      int                capv;
      int                pct;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: mask names consumer 0 only, capacity 16
      send(CMD_PUSH, 32'h0000_0000, 3'd0, 1'b0);
      send(CMD_PUSH, 32'hFFFF_FFFF, 3'd0, 1'b0);
      send(CMD_POP, 32'h0, 3'd0, 1'b0);
      send(CMD_POP, 32'h0, 3'd1, 1'b0);          // consumer not in the mask
      send(CMD_POP, 32'h0, 3'd0, 1'b1);
      send(CMD_POP, 32'h0, 3'd0, 1'b0);          // nothing left to read
      send(CMD_END, 32'h0, 3'd0, 1'b0);          // providers still busy, no effect
      send(CMD_NONE, 32'hFFFF_FFFF, 3'd7, 1'b1); // unused command code

      // push with an empty mask stores nothing
      drain();
      csr_write(CSR_MASK, 8'h00);
      send(CMD_PUSH, 32'h1234_5678, 3'd0, 1'b0);

      // every consumer reads, zero capacity reports full throughout
      drain();
      csr_write(CSR_MASK, 8'hFF);
      csr_write(CSR_CAPACITY, 8'h00);
      send(CMD_PUSH, 32'hA5A5_5A5A, 3'd7, 1'b0);
      send(CMD_POP, 32'h0, 3'd7, 1'b0);
      send(CMD_POP, 32'h0, 3'd3, 1'b0);
      send(CMD_POP, 32'h0, 3'd7, 1'b0);          // already read by this consumer
      send(CMD_NONE, 32'h0, 3'd0, 1'b0);

      // random phases over a spread of masks and capacities
      for (int p = 0; p < 9; p++) begin
         drain();
         case (p % 5)
            0: m = 8'h01;
            1: m = 8'hFF;
            2: m = 8'h80;
            3: m = MASK_W'($urandom_range(1, 255));
            default: m = (p == 4) ? 8'h00 : 8'h55;
         endcase
         case (p % 4)
            0: capv = 16;
            1: capv = 1;
            2: capv = 31;
            default: capv = $urandom_range(0, 31);
         endcase
         case (p % 3)
            0: pct = 85;   // fills the store and runs into overflow
            1: pct = 50;
            default: pct = 25;
         endcase
         csr_write(CSR_MASK, m);
         // upper data bits have no register behind them
         csr_write(CSR_CAPACITY, {3'($urandom_range(0, 7)), 5'(capv)});
         steady = (p == 2 || p == 6);
         run_random(65, pct, 1'b0, (p == 3) ? 30 : -1);
      end

      // termination: raise the mark with entries still queued, then let pops drain it
      drain();
      steady = 0;
      csr_write(CSR_MASK, 8'hFF);
      send(CMD_PUSH, $urandom(), 3'd2, 1'b0);
      send(CMD_PUSH, $urandom(), 3'd5, 1'b0);
      send(CMD_END, 32'h0, 3'd0, 1'b1);
      run_random(70, 40, 1'b1, -1);

      drain();
      repeat (DEPTH_DEFAULT + 8) @(posedge clock);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
